>>> rtl/core/sndet_pkg.sv
// Shared types and constants for the sustained noise detector.
// Word formats, configuration register map, reset values and fixed widths.
// No dependencies.
package sndet_pkg;

  // ADC word width is fixed by the port format
  localparam int SAMPLE_BITS      = 12;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int ALPHA_BITS       = 17;
  localparam int ALPHA_SHIFT      = 16;
  localparam int OUT_FRAC_BITS    = 4;
  localparam int THRESH_BITS      = 16;
  localparam int COUNT_BITS       = 16;
  localparam int OUT_BITS         = SAMPLE_BITS + OUT_FRAC_BITS;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = ALPHA_BITS;

  localparam logic [SAMPLE_BITS-1:0] ZERO_CODE_RST      = SAMPLE_BITS'(2048);
  localparam logic [ALPHA_BITS-1:0]  ALPHA_RST          = ALPHA_BITS'(39322);
  localparam logic [THRESH_BITS-1:0] LOUD_THRESHOLD_RST = THRESH_BITS'(4915);
  localparam logic [COUNT_BITS-1:0]  DURATION_RST       = COUNT_BITS'(800);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ZERO_CODE      = 2'd0,
    CFG_ALPHA          = 2'd1,
    CFG_LOUD_THRESHOLD = 2'd2,
    CFG_DURATION       = 2'd3
  } sndet_cfg_index_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] zero_code;
    logic [ALPHA_BITS-1:0]  alpha_q16;
    logic [THRESH_BITS-1:0] loud_threshold;
    logic [COUNT_BITS-1:0]  duration;
  } sndet_cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw_sample;
    logic                   sample_valid;
  } sndet_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] filtered_sample;
    logic                       loud;
    logic                       alert;
  } sndet_out_t;

endpackage

>>> rtl/core/sndet_cfg.sv
// Configuration register file for the sustained noise detector.
// Depends on sndet_pkg for the register map and reset values.
module sndet_cfg
  import sndet_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output sndet_cfg_t                cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_code      <= ZERO_CODE_RST;
      cfg.alpha_q16      <= ALPHA_RST;
      cfg.loud_threshold <= LOUD_THRESHOLD_RST;
      cfg.duration       <= DURATION_RST;
    end else if (cfg_valid) begin
      case (sndet_cfg_index_t'(cfg_index))
        CFG_ZERO_CODE:      cfg.zero_code      <= cfg_data[SAMPLE_BITS-1:0];
        CFG_ALPHA:          cfg.alpha_q16      <= cfg_data[ALPHA_BITS-1:0];
        CFG_LOUD_THRESHOLD: cfg.loud_threshold <= cfg_data[THRESH_BITS-1:0];
        CFG_DURATION:       cfg.duration       <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/sndet_ema.sv
// Exponential moving average filter with level compare.
// Holds the filter state; one multiply-accumulate per word. Depends on sndet_pkg.
module sndet_ema
  import sndet_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  sndet_in_t                  in_word,
  input  sndet_cfg_t                 cfg,
  output logic signed [OUT_BITS-1:0] filtered_sample,
  output logic                       loud
);

  localparam int W   = SAMPLE_BITS + FRACTION_BITS;
  localparam int XW  = W + 1;
  localparam int DW  = W + 2;
  localparam int PW  = DW + ALPHA_BITS + 1;
  localparam int SW  = PW - ALPHA_SHIFT;
  localparam int NW  = SW + 1;
  localparam int OSH = FRACTION_BITS - OUT_FRAC_BITS;
  localparam int TW  = THRESH_BITS + OSH;

  logic signed [W-1:0]           filter_value;
  logic signed [W-1:0]           filter_value_next;
  logic        [SAMPLE_BITS-1:0] raw;
  logic signed [SAMPLE_BITS:0]   centred;
  logic signed [XW-1:0]          x;
  logic signed [DW-1:0]          diff;
  logic signed [PW-1:0]          prod;
  logic signed [SW-1:0]          delta;
  logic signed [NW-1:0]          sum;
  logic        [TW-1:0]          thr;
  logic signed [NW-1:0]          thr_s;
  logic                          fits;

  always_comb begin
    // failed conversion counts as code zero
    raw     = in_word.sample_valid ? in_word.raw_sample : '0;
    centred = $signed({1'b0, raw}) - $signed({1'b0, cfg.zero_code});
    x       = {centred, {FRACTION_BITS{1'b0}}};
    diff    = DW'(x) - DW'(filter_value);
    prod    = PW'(diff) * $signed({1'b0, cfg.alpha_q16});
    delta   = SW'(prod >>> ALPHA_SHIFT);
    sum     = NW'(delta) + NW'(filter_value);

    // threshold is in 1/16 LSB; compare before saturation
    thr   = {cfg.loud_threshold, {OSH{1'b0}}};
    thr_s = $signed(NW'(thr));
    loud  = (sum > thr_s) || (sum < -thr_s);

    // saturate to the state range
    fits = (sum[NW-1:W-1] == '0) || (sum[NW-1:W-1] == '1);
    if (fits) begin
      filter_value_next = sum[W-1:0];
    end else if (sum[NW-1]) begin
      filter_value_next = {1'b1, {(W-1){1'b0}}};
    end else begin
      filter_value_next = {1'b0, {(W-1){1'b1}}};
    end

    // the state range shifted to 1/16 LSB is exactly the output range
    filtered_sample = filter_value_next[W-1:OSH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_value <= '0;
    end else if (step) begin
      filter_value <= filter_value_next;
    end
  end

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(filter_value))
    else $error("filter state changed without a word");

endmodule

>>> rtl/core/sndet_persist.sv
// Loud-run counter and one-shot alert latch.
// Depends on sndet_pkg for the count width.
module sndet_persist
  import sndet_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  loud,
  input  logic [COUNT_BITS-1:0] duration,
  output logic                  alert
);

  logic [COUNT_BITS-1:0] loud_count;
  logic [COUNT_BITS-1:0] loud_count_next;
  logic                  alert_latched;
  logic                  alert_latched_next;
  logic [COUNT_BITS-1:0] count_inc;

  always_comb begin
    // saturate at the duration
    count_inc = (loud_count < duration) ? loud_count + 1'b1 : loud_count;
    if (loud) begin
      loud_count_next    = count_inc;
      alert              = (count_inc >= duration) && !alert_latched;
      alert_latched_next = alert_latched || alert;
    end else begin
      loud_count_next    = '0;
      alert              = 1'b0;
      alert_latched_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loud_count    <= '0;
      alert_latched <= 1'b0;
    end else if (step) begin
      loud_count    <= loud_count_next;
      alert_latched <= alert_latched_next;
    end
  end

  a_alert_latches: assert property (@(posedge clk) disable iff (rst)
    step && alert |=> alert_latched)
    else $error("alert fired without latching");

  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    alert_latched |-> !alert)
    else $error("alert repeated while latched");

endmodule

>>> rtl/core/sustained_noise_detector_top.sv
// Sustained noise detector top level: input register, filter, run counter, result register.
// Depends on sndet_pkg, sndet_cfg, sndet_ema and sndet_persist.

// One ADC word is taken per clock cycle while results are taken, and each gives
// exactly one result word, passing the input register, then the result register.
// The rate is set by the filter state loop: the multiply-accumulate
// that updates the state is combinational. A word is accepted while a
// finished result still waits to be taken; the block stalls only when both the
// input and result registers are full. Configuration writes are taken every cycle
// and are meant to happen while no word is in flight.
module sustained_noise_detector_top
  import sndet_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sndet_in_t                 in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sndet_out_t                out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  sndet_cfg_t                 cfg;
  sndet_in_t                  in_q;
  logic                       in_q_valid;
  logic                       advance;
  logic                       step;
  logic signed [OUT_BITS-1:0] filtered_sample;
  logic                       loud;
  logic                       alert;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_q_valid || advance;
  assign step     = in_q_valid && advance;

  sndet_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sndet_ema #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ema (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .in_word         (in_q),
    .cfg             (cfg),
    .filtered_sample (filtered_sample),
    .loud            (loud)
  );

  sndet_persist u_persist (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .loud     (loud),
    .duration (cfg.duration),
    .alert    (alert)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.filtered_sample <= filtered_sample;
      out_data.loud            <= loud;
      out_data.alert           <= alert;
    end
  end

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid && $stable(in_q))
    else $error("held input word lost while result stalled");

endmodule
